>>> rtl/dfw_pkg.sv
package dfw_pkg;

    localparam int MaxCoeffs  = 64;
    localparam int MaxWindows = 3;
    localparam int MaxWidth   = 3;
    localparam int DataW      = 32;
    localparam int TapW       = 16;
    localparam int ProdW      = DataW + TapW;
    localparam int SumW       = ProdW + 2;
    localparam int QuotW      = SumW - 14;
    localparam int CoefW      = $clog2(MaxCoeffs);
    localparam int SlotW      = 2;
    localparam int WinW       = 2;
    localparam int CfgDataW   = TapW * MaxWidth;
    localparam int CfgIdxW    = 3;

    // Flush count after reset: (ring width of the reset configuration - 1) / 2.
    localparam logic [1:0] FlushLeftReset = 2'd1;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_VECTOR_ORDER  = 3'd0,
        CFG_WINDOW_COUNT  = 3'd1,
        CFG_WINDOW_WIDTHS = 3'd2,
        CFG_WINDOW0_TAPS  = 3'd3,
        CFG_WINDOW1_TAPS  = 3'd4,
        CFG_WINDOW2_TAPS  = 3'd5,
        CFG_MAGIC_ENABLE  = 3'd6,
        CFG_MAGIC_VALUE   = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [5:0]                           vector_order;
        logic [1:0]                           window_count;
        logic [5:0]                           window_widths;
        logic [MaxWindows-1:0][CfgDataW-1:0]  taps;
        logic                                 magic_enable;
        logic [DataW-1:0]                     magic_value;
    } t_cfg;

    typedef struct packed {
        logic [DataW-1:0] sample;
        logic             use_prev;
        logic             wr_prev;
        logic [SlotW-1:0] slot;
        logic [SlotW-1:0] prev;
        logic [CoefW-1:0] coeff;
        logic             emit;
        logic             last;
    } t_cmd;

    function automatic logic [1:0] active_windows(input logic [1:0] cnt);
        return (cnt == 2'd0) ? 2'd1 : cnt;
    endfunction

    function automatic logic [1:0] width_of(input logic [5:0] widths, input logic [1:0] d);
        logic [1:0] w;
        w = widths[2*d +: 2];
        return (w == 2'd0) ? 2'd1 : w;
    endfunction

    function automatic logic [1:0] ring_width(input t_cfg cfg);
        logic [1:0] w;
        logic [1:0] nw;
        w  = 2'd1;
        nw = active_windows(cfg.window_count);
        for (int d = 0; d < MaxWindows; d++) begin
            if (2'(d) < nw && width_of(cfg.window_widths, 2'(d)) > w) begin
                w = width_of(cfg.window_widths, 2'(d));
            end
        end
        return w;
    endfunction

    // Slot k frames back from slot p in a ring of w slots. The pointer may
    // exceed the ring after the ring shrinks, so up to six wraps are needed.
    function automatic logic [SlotW-1:0] back_slot(input logic [SlotW-1:0] p,
                                                   input logic [1:0] k,
                                                   input logic [1:0] w);
        logic [3:0] t;
        t = 4'(p) + 4'(w) * 4'd3 - 4'(k);
        for (int s = 0; s < 6; s++) begin
            if (t >= 4'(w)) begin
                t = t - 4'(w);
            end
        end
        return t[SlotW-1:0];
    endfunction

endpackage

>>> rtl/dfw_ram.sv
module dfw_ram #(
    parameter int Width = 32,
    parameter int Depth = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);

    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/dfw_front.sv
module dfw_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [dfw_pkg::DataW-1:0]  i_sample_value,
    input  logic                       i_flush,
    input  dfw_pkg::t_cfg              i_cfg,
    input  logic                       i_cfg_we,
    input  logic                       i_full,
    output logic                       o_push,
    output dfw_pkg::t_cmd              o_cmd
);

    logic [dfw_pkg::SlotW-1:0] r_slot_ptr, n_slot_ptr;
    logic [dfw_pkg::CoefW-1:0] r_elem_cnt, n_elem_cnt;
    logic                      r_first, n_first;
    logic [1:0]                r_lead, n_lead;
    logic [1:0]                r_flush_left, n_flush_left;
    logic                      r_reload;

    logic [1:0] ring_w;
    logic [1:0] lag_r;
    logic [1:0] lag_l;
    logic [dfw_pkg::SlotW-1:0] p;
    logic [6:0] frame_len;
    logic       last;
    logic       drop;
    logic       accept;

    assign ring_w    = dfw_pkg::ring_width(i_cfg);
    assign lag_r     = (ring_w - 2'd1) >> 1;
    assign lag_l     = ring_w >> 1;
    assign p         = dfw_pkg::back_slot(r_slot_ptr, 2'd0, ring_w);
    assign frame_len = {1'b0, i_cfg.vector_order} + 7'd1;
    assign last      = ({1'b0, r_elem_cnt} + 7'd1) >= frame_len;
    assign drop      = i_flush && (r_first || r_flush_left == 2'd0);
    assign accept    = i_valid && !i_full;
    assign o_stall   = i_full;
    assign o_push    = accept && !drop;

    always_comb begin
        o_cmd.sample   = i_sample_value;
        o_cmd.use_prev = i_flush;
        o_cmd.wr_prev  = r_first && lag_l != 2'd0;
        o_cmd.slot     = p;
        o_cmd.prev     = dfw_pkg::back_slot(p, 2'd1, ring_w);
        o_cmd.coeff    = r_elem_cnt;
        o_cmd.emit     = r_lead >= lag_r;
        o_cmd.last     = last;
    end

    always_comb begin
        n_slot_ptr   = r_slot_ptr;
        n_elem_cnt   = r_elem_cnt;
        n_first      = r_first;
        n_lead       = r_lead;
        n_flush_left = r_flush_left;
        if (o_push) begin
            if (last) begin
                n_elem_cnt = '0;
                n_slot_ptr = dfw_pkg::back_slot(p, 2'd1, ring_w) == p ? p :
                             dfw_pkg::back_slot(p, 2'(ring_w - 2'd1), ring_w);
                n_first    = 1'b0;
                if (r_lead != 2'd3) begin
                    n_lead = r_lead + 2'd1;
                end
                if (i_flush) begin
                    n_flush_left = r_flush_left - 2'd1;
                end
            end else begin
                n_elem_cnt = r_elem_cnt + 1'b1;
            end
        end
        // A register write before the first item sets the flush count anew.
        if (r_reload && r_first && r_elem_cnt == '0 && r_lead == 2'd0) begin
            n_flush_left = lag_r;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_ptr   <= '0;
            r_elem_cnt   <= '0;
            r_first      <= 1'b1;
            r_lead       <= '0;
            r_flush_left <= dfw_pkg::FlushLeftReset;
            r_reload     <= 1'b0;
        end else begin
            r_slot_ptr   <= n_slot_ptr;
            r_elem_cnt   <= n_elem_cnt;
            r_first      <= n_first;
            r_lead       <= n_lead;
            r_flush_left <= n_flush_left;
            r_reload     <= i_cfg_we;
        end
    end

endmodule

>>> rtl/dfw_queue.sv
module dfw_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  dfw_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_empty,
    output dfw_pkg::t_cmd o_head
);

    dfw_pkg::t_cmd r_q [2];
    logic          r_wp;
    logic          r_rp;
    logic [1:0]    r_cnt;

    assign o_full  = r_cnt == 2'd2;
    assign o_empty = r_cnt == 2'd0;
    assign o_head  = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full || i_pop) else $error("queue overflow");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty) else $error("queue underflow");
`endif

endmodule

>>> rtl/dfw_back.sv
module dfw_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  dfw_pkg::t_cfg              i_cfg,
    input  logic                       i_empty,
    input  dfw_pkg::t_cmd              i_head,
    output logic                       o_pop,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [dfw_pkg::DataW-1:0]  o_result_value,
    output logic [dfw_pkg::WinW-1:0]   o_window_index,
    output logic [dfw_pkg::CoefW-1:0]  o_coeff_index,
    output logic                       o_frame_done,
    output logic                       o_run_last
);

    localparam int NRam = dfw_pkg::MaxWidth;

    logic [1:0] ring_w;
    logic [1:0] lag_r;
    logic [1:0] nw;
    assign ring_w = dfw_pkg::ring_width(i_cfg);
    assign lag_r  = (ring_w - 2'd1) >> 1;
    assign nw     = dfw_pkg::active_windows(i_cfg.window_count);

    // Read stage.
    logic          r_rd_valid;
    dfw_pkg::t_cmd r_rd_cmd;
    logic          rd_go;
    logic          dat_go;
    logic [dfw_pkg::DataW-1:0] rdata [NRam];
    logic [dfw_pkg::DataW-1:0] v;

    // Operand stage.
    logic                      r_op_valid;
    logic [dfw_pkg::DataW-1:0] r_y [NRam];
    logic [dfw_pkg::CoefW-1:0] r_op_coeff;
    logic                      r_op_last;
    logic [1:0]                r_d;
    logic                      mul_go;
    logic                      op_done;
    logic                      op_free;

    // Product stage.
    logic                              r_pr_valid;
    logic signed [dfw_pkg::ProdW-1:0]  r_pr [NRam];
    logic                              r_pr_hit;
    logic [1:0]                        r_pr_win;
    logic [dfw_pkg::CoefW-1:0]         r_pr_coeff;
    logic                              r_pr_fd;
    logic                              r_pr_rl;
    logic                              pr_move;

    // Output register.
    logic                      r_out_valid;
    logic [dfw_pkg::DataW-1:0] r_out_value;
    logic [1:0]                r_out_win;
    logic [dfw_pkg::CoefW-1:0] r_out_coeff;
    logic                      r_out_fd;
    logic                      r_out_rl;

    assign rd_go  = !i_empty && !r_rd_valid;
    assign o_pop  = rd_go;

    assign pr_move = r_pr_valid && (!r_out_valid || !i_stall);
    assign mul_go  = r_op_valid && (!r_pr_valid || pr_move);
    assign op_done = mul_go && r_d == nw - 2'd1;
    assign op_free = !r_op_valid || op_done;
    assign dat_go  = r_rd_valid && op_free;

    assign v = r_rd_cmd.use_prev ? rdata[r_rd_cmd.prev] : r_rd_cmd.sample;

    for (genvar j = 0; j < NRam; j++) begin : g_ring
        logic we;
        assign we = dat_go && (r_rd_cmd.slot == 2'(j) ||
                               (r_rd_cmd.wr_prev && r_rd_cmd.prev == 2'(j)));
        dfw_ram #(
            .Width(dfw_pkg::DataW),
            .Depth(dfw_pkg::MaxCoeffs)
        ) u_ram (
            .i_clk  (i_clk),
            .i_we   (we),
            .i_waddr(r_rd_cmd.coeff),
            .i_wdata(v),
            .i_re   (rd_go),
            .i_raddr(i_head.coeff),
            .o_rdata(rdata[j])
        );
    end

    always_ff @(posedge i_clk) begin
        if (rd_go) begin
            r_rd_cmd <= i_head;
        end
        if (dat_go) begin
            r_op_coeff <= r_rd_cmd.coeff;
            r_op_last  <= r_rd_cmd.last;
            for (int k = 0; k < NRam; k++) begin
                logic [dfw_pkg::SlotW-1:0] s;
                s = dfw_pkg::back_slot(r_rd_cmd.slot, 2'(k), ring_w);
                if (s == r_rd_cmd.slot || (r_rd_cmd.wr_prev && s == r_rd_cmd.prev)) begin
                    r_y[k] <= v;
                end else begin
                    r_y[k] <= rdata[s];
                end
            end
        end
    end

    // One window per cycle while the product stage can move on: three tap products.
    logic [1:0] w_cur;
    logic [1:0] left;
    logic signed [dfw_pkg::ProdW-1:0] prod [NRam];
    logic hit;

    always_comb begin
        w_cur = dfw_pkg::width_of(i_cfg.window_widths, r_d);
        left  = w_cur >> 1;
        hit   = 1'b0;
        for (int i = 0; i < NRam; i++) begin
            logic [2:0] k;
            logic signed [dfw_pkg::DataW-1:0] x;
            logic signed [dfw_pkg::TapW-1:0]  t;
            k = 3'(left) + 3'(lag_r) - 3'(i);
            x = r_y[k[1:0]];
            t = i_cfg.taps[r_d][dfw_pkg::TapW*i +: dfw_pkg::TapW];
            if (2'(i) < w_cur) begin
                prod[i] = x * t;
                if (x == i_cfg.magic_value) begin
                    hit = 1'b1;
                end
            end else begin
                prod[i] = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (mul_go) begin
            for (int i = 0; i < NRam; i++) begin
                r_pr[i] <= prod[i];
            end
            r_pr_hit   <= hit;
            r_pr_win   <= r_d;
            r_pr_coeff <= r_op_coeff;
            r_pr_fd    <= r_op_last && op_done;
            r_pr_rl    <= op_done;
        end
    end

    // Sum, round half up, saturate.
    logic signed [dfw_pkg::SumW-1:0]  sum;
    logic signed [dfw_pkg::QuotW-1:0] quot;
    logic [dfw_pkg::DataW-1:0]        sat;

    always_comb begin
        sum = dfw_pkg::SumW'(r_pr[0]) + dfw_pkg::SumW'(r_pr[1]) +
              dfw_pkg::SumW'(r_pr[2]) + dfw_pkg::SumW'(8192);
        quot = dfw_pkg::QuotW'(sum >>> 14);
        if (quot[dfw_pkg::QuotW-1:dfw_pkg::DataW-1] == '0 ||
            quot[dfw_pkg::QuotW-1:dfw_pkg::DataW-1] == '1) begin
            sat = quot[dfw_pkg::DataW-1:0];
        end else if (quot[dfw_pkg::QuotW-1]) begin
            sat = {1'b1, {(dfw_pkg::DataW-1){1'b0}}};
        end else begin
            sat = {1'b0, {(dfw_pkg::DataW-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (pr_move) begin
            r_out_value <= (i_cfg.magic_enable && r_pr_hit) ? i_cfg.magic_value : sat;
            r_out_win   <= r_pr_win;
            r_out_coeff <= r_pr_coeff;
            r_out_fd    <= r_pr_fd;
            r_out_rl    <= r_pr_rl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_valid  <= 1'b0;
            r_op_valid  <= 1'b0;
            r_d         <= '0;
            r_pr_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (rd_go) begin
                r_rd_valid <= 1'b1;
            end else if (dat_go) begin
                r_rd_valid <= 1'b0;
            end
            if (dat_go) begin
                r_op_valid <= r_rd_cmd.emit;
                r_d        <= '0;
            end else if (op_done) begin
                r_op_valid <= 1'b0;
                r_d        <= '0;
            end else if (mul_go) begin
                r_d <= r_d + 2'd1;
            end
            if (mul_go) begin
                r_pr_valid <= 1'b1;
            end else if (pr_move) begin
                r_pr_valid <= 1'b0;
            end
            if (pr_move) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid        = r_out_valid;
    assign o_result_value = r_out_value;
    assign o_window_index = r_out_win;
    assign o_coeff_index  = r_out_coeff;
    assign o_frame_done   = r_out_fd;
    assign o_run_last     = r_out_rl;

`ifndef SYNTHESIS
    a_win_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_out_win < nw) else $error("window index out of range");
    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_fd |-> r_out_rl) else $error("frame end without item end");
    a_read_before_use: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rd_go |=> !rd_go) else $error("ring read issued twice in a row");
`endif

endmodule

>>> rtl/delta_feature_window_filter_top.sv
// Delta feature window filter. Static feature coefficients enter one per input
// transaction (frames of vector_order+1 coefficients); for each coefficient the
// block emits one output transaction per active window (static, delta,
// acceleration), each a Q2.14-weighted sum of up to three neighboring frames of
// the same coefficient, rounded half up and saturated to Q16.16, delayed by the
// right half of the widest window. Frames before the first one repeat the first
// frame; flush transactions stand for elements of a repeated last frame, and
// flush transactions beyond the right half-width are dropped without output.
// With magic_enable set, a window that reads magic_value yields magic_value.
// A front end accepts and classifies transactions into a two-entry queue; the
// back end reads the frame ring (three 64-word RAMs, one per slot) and runs one
// window per cycle, unless held by output stalls, through a multiply stage and a
// round/saturate stage into an output register, at most one output transaction
// per cycle. The ring read and write-back of an input transaction end before the
// next read. Configuration writes must come only while the block is idle (the
// block itself does not enforce this); registers take effect at once.
module delta_feature_window_filter_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [31:0]                     i_sample_value,
    input  logic                            i_flush,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [31:0]                     o_result_value,
    output logic [1:0]                      o_window_index,
    output logic [5:0]                      o_coeff_index,
    output logic                            o_frame_done,
    output logic                            o_run_last,
    input  logic                            i_cfg_we,
    input  logic [dfw_pkg::CfgIdxW-1:0]     i_cfg_index,
    input  logic [dfw_pkg::CfgDataW-1:0]    i_cfg_data
);

    dfw_pkg::t_cfg r_cfg;
    dfw_pkg::t_cmd push_cmd;
    dfw_pkg::t_cmd head;
    logic          push;
    logic          pop;
    logic          full;
    logic          empty;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.vector_order  <= 6'd24;
            r_cfg.window_count  <= 2'd3;
            r_cfg.window_widths <= 6'd61;
            r_cfg.taps[0]       <= 48'h0000_0000_4000;
            r_cfg.taps[1]       <= 48'h2000_0000_E000;
            r_cfg.taps[2]       <= 48'h4000_8000_4000;
            r_cfg.magic_enable  <= 1'b0;
            r_cfg.magic_value   <= '0;
        end else if (i_cfg_we) begin
            unique case (dfw_pkg::t_cfg_idx'(i_cfg_index))
                dfw_pkg::CFG_VECTOR_ORDER:  r_cfg.vector_order  <= i_cfg_data[5:0];
                dfw_pkg::CFG_WINDOW_COUNT:  r_cfg.window_count  <= i_cfg_data[1:0];
                dfw_pkg::CFG_WINDOW_WIDTHS: r_cfg.window_widths <= i_cfg_data[5:0];
                dfw_pkg::CFG_WINDOW0_TAPS:  r_cfg.taps[0]       <= i_cfg_data;
                dfw_pkg::CFG_WINDOW1_TAPS:  r_cfg.taps[1]       <= i_cfg_data;
                dfw_pkg::CFG_WINDOW2_TAPS:  r_cfg.taps[2]       <= i_cfg_data;
                dfw_pkg::CFG_MAGIC_ENABLE:  r_cfg.magic_enable  <= i_cfg_data[0];
                dfw_pkg::CFG_MAGIC_VALUE:   r_cfg.magic_value   <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    dfw_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_sample_value(i_sample_value),
        .i_flush       (i_flush),
        .i_cfg         (r_cfg),
        .i_cfg_we      (i_cfg_we),
        .i_full        (full),
        .o_push        (push),
        .o_cmd         (push_cmd)
    );

    dfw_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_cmd  (push_cmd),
        .i_pop  (pop),
        .o_full (full),
        .o_empty(empty),
        .o_head (head)
    );

    dfw_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_empty       (empty),
        .i_head        (head),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_result_value(o_result_value),
        .o_window_index(o_window_index),
        .o_coeff_index (o_coeff_index),
        .o_frame_done  (o_frame_done),
        .o_run_last    (o_run_last)
    );

endmodule

>>> verif/delta_feature_window_filter_top_test.sv
`timescale 1ns / 100ps

// Self-checking bench for the delta feature window filter.
// A shadow copy of the frame ring, pointers and registers inside the bench
// predicts every window result. The expected results are queued when an input
// transaction is accepted. A monitor compares each accepted output transaction
// with the oldest entry in that queue.
module delta_feature_window_filter_top_test;

    localparam int IdleLimit = 5000;   // cycles without any transaction
    localparam int SettleCycles = 20;  // pipeline depth margin after a drain
    localparam int HoldCycles = 300;   // long receiver hold-off

    typedef struct {
        logic [31:0] value;
        logic [1:0]  win;
        logic [5:0]  coeff;
        logic        frame_done;
        logic        run_last;
    } t_window_result;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         i_valid;
    logic                         o_stall;
    logic [31:0]                  i_sample_value;
    logic                         i_flush;
    logic                         o_valid;
    logic                         i_stall;
    logic [31:0]                  o_result_value;
    logic [1:0]                   o_window_index;
    logic [5:0]                   o_coeff_index;
    logic                         o_frame_done;
    logic                         o_run_last;
    logic                         i_cfg_we;
    logic [dfw_pkg::CfgIdxW-1:0]  i_cfg_index;
    logic [dfw_pkg::CfgDataW-1:0] i_cfg_data;

    delta_feature_window_filter_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_sample_value (i_sample_value),
        .i_flush        (i_flush),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_result_value (o_result_value),
        .o_window_index (o_window_index),
        .o_coeff_index  (o_coeff_index),
        .o_frame_done   (o_frame_done),
        .o_run_last     (o_run_last),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Shadow registers.
    logic [5:0]  sh_order;
    logic [1:0]  sh_count;
    logic [5:0]  sh_widths;
    logic [47:0] sh_taps [3];
    logic        sh_magic_en;
    logic [31:0] sh_magic_val;

    // Shadow datapath state.
    logic [31:0] sh_frames [3][64];
    int          sh_slot;
    int          sh_elem;
    bit          sh_first;
    int          sh_lead;
    int          sh_flush_left;

    t_window_result pending_results[$];

    int errors = 0;
    int items_sent = 0;
    int results_checked = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    bit hold_request = 0;

    function automatic int tap_count(input int d);
        int w;
        w = sh_widths[2*d +: 2];
        return (w == 0) ? 1 : w;
    endfunction

    function automatic int live_windows();
        return (sh_count == 0) ? 1 : sh_count;
    endfunction

    function automatic int ring_depth();
        int w;
        w = 1;
        for (int d = 0; d < live_windows(); d++) begin
            if (tap_count(d) > w) begin
                w = tap_count(d);
            end
        end
        return w;
    endfunction

    // Round half up at bit 14 and saturate the Q20.30 sum to Q16.16.
    function automatic logic [31:0] round_saturate(input longint sum);
        longint q;
        q = (sum + 64'sd8192) >>> 14;
        if (q > 64'sd2147483647) begin
            q = 64'sd2147483647;
        end else if (q < -64'sd2147483648) begin
            q = -64'sd2147483648;
        end
        return q[31:0];
    endfunction

    // Updates the shadow state for one accepted transaction and queues the
    // window results it causes.
    task automatic predict_windows(input logic [31:0] sample, input logic flush);
        int W, R, L, p, m, n, nw, w, left, slot;
        bit last, hit;
        logic [31:0] v, x;
        longint sum;
        t_window_result r;
        W = ring_depth();
        R = (W - 1) / 2;
        L = W / 2;
        p = sh_slot % W;
        m = sh_elem % 64;
        n = sh_order + 1;
        nw = live_windows();
        last = (sh_elem + 1 >= n);
        if (flush) begin
            // A flush before any data, or beyond the right half-width, is dropped.
            if (sh_first || sh_flush_left == 0) begin
                return;
            end
            v = sh_frames[(p + W - 1) % W][m];
        end else begin
            v = sample;
        end
        sh_frames[p][m] = v;
        // The first frame also stands in for the frames before it.
        if (sh_first) begin
            for (int j = 1; j <= L; j++) begin
                sh_frames[(p + W - j) % W][m] = v;
            end
        end
        if (sh_lead >= R) begin
            for (int d = 0; d < nw; d++) begin
                w = tap_count(d);
                left = w / 2;
                sum = 0;
                hit = 0;
                for (int i = 0; i < w; i++) begin
                    slot = (p + 2 * W + i - left - R) % W;
                    x = sh_frames[slot][m];
                    if (x == sh_magic_val) begin
                        hit = 1;
                    end
                    sum += longint'($signed(sh_taps[d][16*i +: 16])) * longint'($signed(x));
                end
                r.value = (sh_magic_en && hit) ? sh_magic_val : round_saturate(sum);
                r.win = 2'(d);
                r.coeff = 6'(m);
                r.frame_done = last && (d + 1 == nw);
                r.run_last = (d + 1 == nw);
                pending_results.push_back(r);
            end
        end
        if (last) begin
            sh_elem = 0;
            sh_slot = (p + 1) % W;
            sh_first = 0;
            if (sh_lead < 3) begin
                sh_lead++;
            end
            if (flush) begin
                sh_flush_left--;
            end
        end else begin
            sh_elem = (sh_elem + 1) % 64;
        end
    endtask

    // Writes one register; only called while the block is idle.
    task automatic write_reg(input dfw_pkg::t_cfg_idx idx, input logic [47:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            dfw_pkg::CFG_VECTOR_ORDER:  sh_order = data[5:0];
            dfw_pkg::CFG_WINDOW_COUNT:  sh_count = data[1:0];
            dfw_pkg::CFG_WINDOW_WIDTHS: sh_widths = data[5:0];
            dfw_pkg::CFG_WINDOW0_TAPS:  sh_taps[0] = data;
            dfw_pkg::CFG_WINDOW1_TAPS:  sh_taps[1] = data;
            dfw_pkg::CFG_WINDOW2_TAPS:  sh_taps[2] = data;
            dfw_pkg::CFG_MAGIC_ENABLE:  sh_magic_en = data[0];
            dfw_pkg::CFG_MAGIC_VALUE:   sh_magic_val = data[31:0];
            default: ;
        endcase
        // Before any data has been taken, the flush budget follows the new setup.
        if (sh_first && sh_elem == 0 && sh_lead == 0) begin
            sh_flush_left = (ring_depth() - 1) / 2;
        end
    endtask

    // Offers one input transaction and waits until the block takes it. Valid
    // stays high afterwards so back-to-back transactions need no gap.
    task automatic send_sample(input logic [31:0] sample, input logic flush);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_sample_value <= sample;
        i_flush <= flush;
        forever begin
            @(posedge i_clk);
            if (!o_stall) begin
                break;
            end
        end
        items_sent++;
        predict_windows(sample, flush);
    endtask

    // Lowers valid and waits until every queued result has come out.
    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SettleCycles) @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_sample();
        case ($urandom_range(15))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return sh_magic_val;
            3: return 32'(($urandom_range(2047)) - 1024) << 16;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [47:0] pick_taps();
        case ($urandom_range(5))
            0: return {16'h7fff, 16'h7fff, 16'h7fff};
            1: return {16'h8000, 16'h8000, 16'h8000};
            2: return {16'h4000, 16'hc000, 16'h4000};
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic random_setup();
        write_reg(dfw_pkg::CFG_VECTOR_ORDER,
                  ($urandom_range(7) == 0) ? 48'd63 : 48'($urandom_range(7)));
        write_reg(dfw_pkg::CFG_WINDOW_COUNT, 48'($urandom_range(3)));
        write_reg(dfw_pkg::CFG_WINDOW_WIDTHS, 48'($urandom_range(63)));
        write_reg(dfw_pkg::CFG_WINDOW0_TAPS, pick_taps());
        write_reg(dfw_pkg::CFG_WINDOW1_TAPS, pick_taps());
        write_reg(dfw_pkg::CFG_WINDOW2_TAPS, pick_taps());
        write_reg(dfw_pkg::CFG_MAGIC_ENABLE, 48'($urandom_range(1)));
        write_reg(dfw_pkg::CFG_MAGIC_VALUE,
                  ($urandom_range(3) == 0) ? 48'h8000_0000 : 48'($urandom));
    endtask

    // Flush transactions before any data must be dropped.
    task automatic test_flush_before_data();
        for (int k = 0; k < 3; k++) begin
            send_sample($urandom, 1'b1);
        end
        drain();
    endtask

    // Largest frames and three 3-tap windows. Two full frames write every ring
    // entry, so no later setup can read a word that was never stored.
    task automatic test_full_ring();
        write_reg(dfw_pkg::CFG_VECTOR_ORDER, 48'd63);
        write_reg(dfw_pkg::CFG_WINDOW_COUNT, 48'd3);
        write_reg(dfw_pkg::CFG_WINDOW_WIDTHS, 48'd63);
        write_reg(dfw_pkg::CFG_WINDOW0_TAPS, {16'h7fff, 16'h8000, 16'h7fff});
        write_reg(dfw_pkg::CFG_WINDOW1_TAPS, {16'h2000, 16'h0000, 16'he000});
        write_reg(dfw_pkg::CFG_WINDOW2_TAPS, {16'h4000, 16'h8000, 16'h4000});
        write_reg(dfw_pkg::CFG_MAGIC_ENABLE, 48'd0);
        write_reg(dfw_pkg::CFG_MAGIC_VALUE, 48'd0);
        for (int k = 0; k < 128; k++) begin
            send_sample(pick_sample(), 1'b0);
        end
        drain();
    endtask

    // The first flush frame closes the stream; the ones after it are dropped.
    task automatic test_flush_tail();
        for (int k = 0; k < 70; k++) begin
            send_sample($urandom, 1'b1);
        end
        drain();
    endtask

    // One-coefficient frames with saturating taps and magic markers.
    task automatic test_saturate_and_magic();
        write_reg(dfw_pkg::CFG_VECTOR_ORDER, 48'd0);
        write_reg(dfw_pkg::CFG_MAGIC_ENABLE, 48'd1);
        write_reg(dfw_pkg::CFG_MAGIC_VALUE, 48'h7fff_ffff);
        send_sample(32'h7fff_ffff, 1'b0);
        send_sample(32'h8000_0000, 1'b0);
        send_sample(32'h8000_0000, 1'b0);
        send_sample(32'h0000_0001, 1'b0);
        drain();
        write_reg(dfw_pkg::CFG_MAGIC_VALUE, 48'h8000_0000);
        send_sample(32'h7fff_ffff, 1'b0);
        send_sample(32'h7fff_ffff, 1'b0);
        send_sample(32'h8000_0000, 1'b0);
        drain();
    endtask

    // A window count of zero and tap-count codes of zero both mean one.
    task automatic test_zero_codes();
        write_reg(dfw_pkg::CFG_WINDOW_COUNT, 48'd0);
        write_reg(dfw_pkg::CFG_WINDOW_WIDTHS, 48'd0);
        write_reg(dfw_pkg::CFG_MAGIC_ENABLE, 48'd0);
        for (int k = 0; k < 4; k++) begin
            send_sample(pick_sample(), 1'b0);
        end
        drain();
        write_reg(dfw_pkg::CFG_WINDOW_COUNT, 48'd2);
        write_reg(dfw_pkg::CFG_WINDOW_WIDTHS, 48'b00_00_11);
        for (int k = 0; k < 4; k++) begin
            send_sample(pick_sample(), 1'b0);
        end
        drain();
    endtask

    // Random setup and random content; flush transactions appear now and then.
    task automatic test_random_phase(input int send_pct, input int recv_pct, input bit squeeze);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        random_setup();
        for (int k = 0; k < 30; k++) begin
            if (squeeze && k == 10) begin
                hold_request = 1;
            end
            send_sample(pick_sample(), ($urandom_range(15) == 0));
        end
        drain();
    endtask

    // Receiver side: random stall, plus one long hold-off on request.
    int hold_left = 0;
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_stall <= 1'b1;
        end else if (hold_request) begin
            hold_request = 0;
            hold_left <= HoldCycles;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Output monitor.
    always @(posedge i_clk) begin
        t_window_result e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result value=%h win=%0d coeff=%0d", $time,
                         o_result_value, o_window_index, o_coeff_index);
                errors++;
            end else begin
                e = pending_results.pop_front();
                results_checked++;
                if (o_result_value !== e.value || o_window_index !== e.win ||
                    o_coeff_index !== e.coeff || o_frame_done !== e.frame_done ||
                    o_run_last !== e.run_last) begin
                    $display("%0t: mismatch expected value=%h win=%0d coeff=%0d done=%b last=%b",
                             $time, e.value, e.win, e.coeff, e.frame_done, e.run_last);
                    $display("%0t:          actual   value=%h win=%0d coeff=%0d done=%b last=%b",
                             $time, o_result_value, o_window_index, o_coeff_index,
                             o_frame_done, o_run_last);
                    errors++;
                end
            end
        end
    end

    // Watchdog on cycles with no transaction on either side.
    int quiet_cycles = 0;
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IdleLimit) begin
            $display("%0t: timeout with %0d results outstanding", $time,
                     pending_results.size());
            $display("tb: failure");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_sample_value <= '0;
        i_flush <= 1'b0;
        i_stall <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_index <= dfw_pkg::CFG_VECTOR_ORDER;
        i_cfg_data <= '0;
        sh_order = 6'd24;
        sh_count = 2'd3;
        sh_widths = 6'd61;
        sh_taps[0] = 48'd16384;
        sh_taps[1] = 48'd35184372146176;
        sh_taps[2] = 48'd70370891677696;
        sh_magic_en = 0;
        sh_magic_val = '0;
        for (int s = 0; s < 3; s++) begin
            for (int c = 0; c < 64; c++) begin
                sh_frames[s][c] = '0;
            end
        end
        sh_slot = 0;
        sh_elem = 0;
        sh_first = 1;
        sh_lead = 0;
        sh_flush_left = (ring_depth() - 1) / 2;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_flush_before_data();
        test_full_ring();
        test_flush_tail();
        test_saturate_and_magic();
        test_zero_codes();
        test_random_phase(17, 66, 0);
        test_random_phase(66, 17, 0);
        test_random_phase(0, 0, 1);

        $display("Sent %0d input transactions and checked %0d window results", items_sent,
                 results_checked);
        $display("Covered flush edges, saturation, magic markers, zero codes and a long hold-off");
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

>>> delta_feature_window_filter_top.f
rtl/dfw_pkg.sv
rtl/dfw_ram.sv
rtl/dfw_front.sv
rtl/dfw_queue.sv
rtl/dfw_back.sv
rtl/delta_feature_window_filter_top.sv
verif/delta_feature_window_filter_top_test.sv
